[sv/isms_pkg.sv]
// Shared types, constants and helpers of the interval statistics block.
package isms_pkg;

  localparam int CountBits  = 16;
  localparam int SumBits    = CountBits + 32;
  localparam int DivCntBits = $clog2(SumBits);
  localparam int CntExtBits = (CountBits > 16) ? CountBits : 16;
  localparam int NumChan    = 6;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_FINISH = 2'd1;
  localparam logic [1:0] REG_LEN    = 2'd2;
  localparam logic [1:0] REG_FULL   = 2'd3;

  localparam logic [CountBits-1:0] CountLimit = {CountBits{1'b1}};

  typedef enum logic {
    CMD_SAMPLE,
    CMD_FLUSH
  } cmd_kind_e;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] finish_time;
    logic [31:0] interval_len;
    logic        full_info;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [31:0]      bin;
    logic [31:0]      stime;
    logic [5:0][31:0] vals;
  } cmd_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_LOAD,
    BE_DIV,
    BE_EMIT,
    BE_APPLY
  } back_state_e;

  function automatic logic [15:0] sat_count(input logic [CountBits-1:0] cnt);
    logic [CntExtBits-1:0] ext;
    ext = CntExtBits'(cnt);
    if (ext > CntExtBits'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return ext[15:0];
  endfunction

endpackage

[sv/isms_div.sv]
// Iterative restoring unsigned divider, one quotient bit per cycle.
module isms_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [isms_pkg::SumBits-1:0] dividend_i,
  input  logic [31:0]                 divisor_i,
  output logic                        done_o,
  output logic [isms_pkg::SumBits-1:0] quotient_o
);

  logic                            busy_q, busy_d;
  logic [isms_pkg::DivCntBits-1:0] cnt_q, cnt_d;
  logic [isms_pkg::SumBits-1:0]    quo_q, quo_d;
  logic [31:0]                     rem_q, rem_d;
  logic [31:0]                     dvs_q, dvs_d;
  logic                            done_q, done_d;
  logic [32:0]                     r_ext;
  logic                            ge;

  always_comb begin
    r_ext  = {rem_q, quo_q[isms_pkg::SumBits-1]};
    ge     = r_ext >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 32'(r_ext - {1'b0, dvs_q}) : r_ext[31:0];
      quo_d = {quo_q[isms_pkg::SumBits-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == isms_pkg::DivCntBits'(isms_pkg::SumBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[sv/isms_cmdq.sv]
// Two-entry command queue between front and back.
module isms_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  isms_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output isms_pkg::cmd_t data_o
);

  isms_pkg::cmd_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

endmodule

[sv/isms_front.sv]
// Front end: accepts items, screens the window and works out the bin number.
module isms_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isms_pkg::cfg_t   cfg_i,
  input  logic             push,
  output logic             full,
  input  logic             action_i,
  input  logic [31:0]      sample_time_i,
  input  logic [5:0][31:0] vals_i,
  output logic             cmd_push_o,
  output isms_pkg::cmd_t   cmd_o,
  input  logic             cmd_full_i
);

  isms_pkg::front_state_e       state_q, state_d;
  isms_pkg::cmd_t               cmd_q, cmd_d;
  logic                         div_start, div_done;
  logic [isms_pkg::SumBits-1:0] div_quo;
  logic [31:0]                  div_den;
  logic [31:0]                  offset;

  assign offset  = sample_time_i - cfg_i.start_time;
  assign div_den = (cfg_i.interval_len == 32'd0) ? 32'd1 : cfg_i.interval_len;

  isms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (isms_pkg::SumBits'(offset)),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    div_start  = 1'b0;
    cmd_push_o = 1'b0;
    full       = (state_q != isms_pkg::FE_IDLE);
    case (state_q)
      isms_pkg::FE_IDLE: begin
        if (push) begin
          cmd_d.stime = sample_time_i;
          cmd_d.vals  = vals_i;
          cmd_d.bin   = '0;
          if (action_i) begin
            cmd_d.kind = isms_pkg::CMD_FLUSH;
            state_d    = isms_pkg::FE_PUSH;
          end else if (sample_time_i < cfg_i.start_time) begin
            state_d = isms_pkg::FE_IDLE;
          end else if (cfg_i.finish_time != 32'd0 && sample_time_i > cfg_i.finish_time) begin
            cmd_d.kind = isms_pkg::CMD_FLUSH;
            state_d    = isms_pkg::FE_PUSH;
          end else begin
            cmd_d.kind = isms_pkg::CMD_SAMPLE;
            div_start  = 1'b1;
            state_d    = isms_pkg::FE_DIV;
          end
        end
      end
      isms_pkg::FE_DIV: begin
        if (div_done) begin
          cmd_d.bin = div_quo[31:0];
          state_d   = isms_pkg::FE_PUSH;
        end
      end
      isms_pkg::FE_PUSH: begin
        if (!cmd_full_i) begin
          cmd_push_o = 1'b1;
          state_d    = isms_pkg::FE_IDLE;
        end
      end
      default: state_d = isms_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isms_pkg::FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_o = cmd_q;

endmodule

[sv/isms_back.sv]
// Back end: keeps the open group, closes it and emits one record per active channel (six with full info, else three).
module isms_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           full_info_i,
  input  logic           cmd_empty_i,
  input  isms_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic [2:0]     channel_o,
  output logic [31:0]    group_time_o,
  output logic [15:0]    sample_count_o,
  output logic [31:0]    mean_value_o,
  output logic [31:0]    min_value_o,
  output logic [31:0]    max_value_o,
  output logic           last_o
);

  localparam int SB = isms_pkg::SumBits;
  localparam int CB = isms_pkg::CountBits;

  isms_pkg::back_state_e state_q, state_d;
  isms_pkg::cmd_t        cmd_q;
  logic                  open_q;
  logic [31:0]           open_bin_q;
  logic [31:0]           gstart_q;
  logic [CB-1:0]         samples_q;
  logic signed [SB-1:0]  sum_q [isms_pkg::NumChan];
  logic signed [31:0]    min_q [isms_pkg::NumChan];
  logic signed [31:0]    max_q [isms_pkg::NumChan];
  logic [2:0]            k_q;
  logic                  out_valid_q;
  logic                  latch_cmd, do_emit, do_apply, do_close_clr;
  logic                  div_start, div_done;
  logic [SB-1:0]         div_quo, sum_abs, q_signed;
  logic                  sum_neg;
  logic [2:0]            last_k;

  assign sum_neg  = sum_q[k_q][SB-1];
  assign sum_abs  = sum_neg ? SB'(-sum_q[k_q]) : SB'(sum_q[k_q]);
  assign q_signed = sum_neg ? SB'(-div_quo) : div_quo;
  assign last_k   = full_info_i ? 3'd5 : 3'd2;

  isms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs),
    .divisor_i  (32'(samples_q)),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d      = state_q;
    cmd_pop_o    = 1'b0;
    latch_cmd    = 1'b0;
    div_start    = 1'b0;
    do_emit      = 1'b0;
    do_apply     = 1'b0;
    do_close_clr = 1'b0;
    case (state_q)
      isms_pkg::BE_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          latch_cmd = 1'b1;
          if (open_q && (cmd_i.kind == isms_pkg::CMD_FLUSH || cmd_i.bin != open_bin_q)) begin
            state_d = isms_pkg::BE_LOAD;
          end else if (cmd_i.kind == isms_pkg::CMD_SAMPLE) begin
            state_d = isms_pkg::BE_APPLY;
          end
        end
      end
      isms_pkg::BE_LOAD: begin
        div_start = 1'b1;
        state_d   = isms_pkg::BE_DIV;
      end
      isms_pkg::BE_DIV: begin
        if (div_done) state_d = isms_pkg::BE_EMIT;
      end
      isms_pkg::BE_EMIT: begin
        if (!out_valid_q || pop) begin
          do_emit = 1'b1;
          if (k_q == last_k) begin
            do_close_clr = 1'b1;
            state_d = (cmd_q.kind == isms_pkg::CMD_SAMPLE) ? isms_pkg::BE_APPLY
                                                           : isms_pkg::BE_IDLE;
          end else begin
            state_d = isms_pkg::BE_LOAD;
          end
        end
      end
      isms_pkg::BE_APPLY: begin
        do_apply = 1'b1;
        state_d  = isms_pkg::BE_IDLE;
      end
      default: state_d = isms_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isms_pkg::BE_IDLE;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (latch_cmd) k_q <= '0;
      else if (do_emit) k_q <= k_q + 3'd1;
      if (do_emit) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
      if (do_close_clr) open_q <= 1'b0;
      else if (do_apply) open_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch_cmd) cmd_q <= cmd_i;
    if (do_emit) begin
      channel_o      <= k_q;
      group_time_o   <= gstart_q;
      sample_count_o <= isms_pkg::sat_count(samples_q);
      mean_value_o   <= q_signed[31:0];
      min_value_o    <= min_q[k_q];
      max_value_o    <= max_q[k_q];
      last_o         <= (k_q == last_k);
    end
    if (do_apply) begin
      open_bin_q <= cmd_q.bin;
      if (!open_q) begin
        gstart_q  <= cmd_q.stime;
        samples_q <= CB'(1);
      end else if (samples_q < isms_pkg::CountLimit) begin
        samples_q <= samples_q + CB'(1);
      end
      for (int i = 0; i < isms_pkg::NumChan; i++) begin
        if (!open_q) begin
          sum_q[i] <= SB'($signed(cmd_q.vals[i]));
          min_q[i] <= $signed(cmd_q.vals[i]);
          max_q[i] <= $signed(cmd_q.vals[i]);
        end else begin
          if ($signed(cmd_q.vals[i]) < min_q[i]) min_q[i] <= $signed(cmd_q.vals[i]);
          if ($signed(cmd_q.vals[i]) > max_q[i]) max_q[i] <= $signed(cmd_q.vals[i]);
          if (samples_q < isms_pkg::CountLimit) begin
            sum_q[i] <= sum_q[i] + SB'($signed(cmd_q.vals[i]));
          end
        end
      end
    end
  end

  assign empty = !out_valid_q;

  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q && state_q != isms_pkg::BE_APPLY) |-> samples_q != '0)
    else $error("open group with zero count");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q && state_q == isms_pkg::BE_IDLE) |-> min_q[0] <= max_q[0])
    else $error("min above max");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_emit |-> k_q <= last_k)
    else $error("record channel beyond active set");

  a_emit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_emit |=> !empty)
    else $error("emitted record not presented");

endmodule

[sv/interval_min_max_mean_stats_core.sv]
// Top level of the interval min/max/mean statistics block.
// Channel  | Direction | Handshake          | Payload
// input    | in        | push / full        | action, sample_time, six channel values
// result   | out       | empty / pop        | channel, group_time, count, mean, min, max, last
// config   | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
// In the front a sample waits on the 48-step shared-width divider for its bin number.
// Closing a group runs one division per emitted record, for its mean.
// Flush and out-of-window items skip the divider; items before the window vanish.
// The front and back stall independently through a two-entry command queue.
// Reset is asynchronous, active low; no clearing pass is needed.
module interval_min_max_mean_stats_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [31:0] sample_time_i,
  input  logic [31:0] dt_final_i,
  input  logic [31:0] dt_first_i,
  input  logic [31:0] dt_second_i,
  input  logic [31:0] accel_max_i,
  input  logic [31:0] visc_dt_max_i,
  input  logic [31:0] vel_max_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  channel_o,
  output logic [31:0] group_time_o,
  output logic [15:0] sample_count_o,
  output logic [31:0] mean_value_o,
  output logic [31:0] min_value_o,
  output logic [31:0] max_value_o,
  output logic        last_o
);

  isms_pkg::cfg_t   cfg_q;
  isms_pkg::cmd_t   fcmd, qcmd;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [5:0][31:0] vals;

  assign vals = {vel_max_i, visc_dt_max_i, accel_max_i, dt_second_i, dt_first_i, dt_final_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_time   <= '0;
      cfg_q.finish_time  <= '0;
      cfg_q.interval_len <= 32'd65536;
      cfg_q.full_info    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        isms_pkg::REG_START:  cfg_q.start_time   <= cfg_data_i;
        isms_pkg::REG_FINISH: cfg_q.finish_time  <= cfg_data_i;
        isms_pkg::REG_LEN:    cfg_q.interval_len <= cfg_data_i;
        isms_pkg::REG_FULL:   cfg_q.full_info    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  isms_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .sample_time_i (sample_time_i),
    .vals_i        (vals),
    .cmd_push_o    (cmd_push),
    .cmd_o         (fcmd),
    .cmd_full_i    (cmd_full)
  );

  isms_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (fcmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (qcmd)
  );

  isms_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .full_info_i    (cfg_q.full_info),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (qcmd),
    .cmd_pop_o      (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .channel_o      (channel_o),
    .group_time_o   (group_time_o),
    .sample_count_o (sample_count_o),
    .mean_value_o   (mean_value_o),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .last_o         (last_o)
  );

endmodule
